@@ rtl/wfpa_pkg.sv @@
// Types and constants shared by the worst-fit partition allocator.
// No dependencies.
package wfpa_pkg;

   localparam int IDX_BITS  = 4;
   localparam int OUT_BITS  = 16;
   localparam int IN_BITS   = 16;
   localparam int CFG_BITS  = 5;
   localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd16;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_ALLOC = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                granted;
      logic [IDX_BITS-1:0] chosen_block;
      logic [OUT_BITS-1:0] leftover;
   } rsp_type;

endpackage

@@ rtl/worst_fit_partition_allocator_core.sv @@
// Sequence: a load request writes the size memory and gets no response; an allocate
// request scans L entries, L = num_blocks capped at NUM_PARTITIONS: one size memory
// read a cycle, then a drain of the last read, then a registered response.
// Throughput: one load per cycle while no allocate is in progress; an allocate holds
// off all requests until it responds, and a stalled response in the result stage delays that.
// Reset: synchronous, active high; all partitions free and size zero, num_blocks 16.
module worst_fit_partition_allocator_core #(
   parameter int NUM_PARTITIONS = 16,
   parameter int SIZE_BITS      = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [wfpa_pkg::IDX_BITS-1:0] req_block_index,
   input  logic [wfpa_pkg::IN_BITS-1:0]  req_block_size,
   input  logic [wfpa_pkg::IN_BITS-1:0]  req_request_size,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_granted,
   output logic [wfpa_pkg::IDX_BITS-1:0] rsp_chosen_block,
   output logic [wfpa_pkg::OUT_BITS-1:0] rsp_leftover,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [wfpa_pkg::CFG_BITS-1:0] csr_num_blocks
);
   import wfpa_pkg::*;

   localparam int CNT_W = $clog2(NUM_PARTITIONS + 1);
   localparam int LIM_W = (CNT_W > CFG_BITS) ? CNT_W : CFG_BITS;

   logic [CFG_BITS-1:0] num_blocks_ff, num_blocks_in;
   logic [LIM_W-1:0]    limit;
   rsp_type             rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      num_blocks_in = num_blocks_ff;
      if (csr_valid && csr_ready) begin
         num_blocks_in = csr_num_blocks;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_blocks_ff <= CFG_RESET;
      end else begin
         num_blocks_ff <= num_blocks_in;
      end
   end

   always_comb begin
      if (32'(num_blocks_ff) > NUM_PARTITIONS) begin
         limit = LIM_W'(NUM_PARTITIONS);
      end else begin
         limit = LIM_W'(num_blocks_ff);
      end
   end

   wfpa_scan #(
      .NUM_PARTITIONS (NUM_PARTITIONS),
      .SIZE_BITS      (SIZE_BITS),
      .LIM_W          (LIM_W)
   ) u_scan (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_block_index  (req_block_index),
      .req_block_size   (req_block_size),
      .req_request_size (req_request_size),
      .limit            (limit),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp              (rsp)
   );

   assign rsp_granted      = rsp.granted;
   assign rsp_chosen_block = rsp.chosen_block;
   assign rsp_leftover     = rsp.leftover;

endmodule

@@ rtl/wfpa_size_mem.sv @@
// Partition size memory: one write port, one read port, registered read data.
// Depends on nothing.
module wfpa_size_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/wfpa_scan.sv @@
// Request sequencer: loads partitions, scans the size memory one entry a cycle
// and keeps the worst-fit candidate. Depends on wfpa_pkg and wfpa_size_mem.
module wfpa_scan #(
   parameter int NUM_PARTITIONS = 16,
   parameter int SIZE_BITS      = 16,
   parameter int LIM_W          = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [wfpa_pkg::IDX_BITS-1:0] req_block_index,
   input  logic [wfpa_pkg::IN_BITS-1:0]  req_block_size,
   input  logic [wfpa_pkg::IN_BITS-1:0]  req_request_size,
   input  logic [LIM_W-1:0]              limit,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output wfpa_pkg::rsp_type             rsp
);
   import wfpa_pkg::*;

   localparam int IDX_W = $clog2(NUM_PARTITIONS);

   state_type               state_ff, state_in;
   logic [SIZE_BITS-1:0]    req_ff, req_in;
   logic [LIM_W-1:0]        limit_ff, limit_in;
   logic [LIM_W-1:0]        addr_ff, addr_in;
   logic                    pend_ff, pend_in;
   logic [IDX_W-1:0]        pidx_ff, pidx_in;
   logic                    found_ff, found_in;
   logic [IDX_W-1:0]        best_ff, best_in;
   logic [SIZE_BITS-1:0]    bleft_ff, bleft_in;
   logic [NUM_PARTITIONS-1:0] used_ff, used_in;
   logic [NUM_PARTITIONS-1:0] loaded_ff, loaded_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    accept;
   logic                    issue;
   logic                    mem_we;
   logic [IDX_W-1:0]        mem_waddr;
   logic [SIZE_BITS-1:0]    mem_wdata;
   logic [SIZE_BITS-1:0]    mem_rdata;
   logic [SIZE_BITS-1:0]    cand_size;
   logic [SIZE_BITS-1:0]    cand_left;
   logic                    fits;
   logic                    take;

   wfpa_size_mem #(
      .DEPTH (NUM_PARTITIONS),
      .WIDTH (SIZE_BITS)
   ) u_size_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (issue),
      .rd_addr (addr_ff[IDX_W-1:0]),
      .rd_data (mem_rdata)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign issue     = (state_ff == ST_SCAN) && (addr_ff < limit_ff);

   assign mem_waddr = IDX_W'(req_block_index);
   assign mem_wdata = SIZE_BITS'(req_block_size);
   assign mem_we    = accept && (req_operation == OP_LOAD) &&
                      (32'(req_block_index) < NUM_PARTITIONS);

   assign cand_size = loaded_ff[pidx_ff] ? mem_rdata : '0;
   assign cand_left = cand_size - req_ff;
   assign fits      = pend_ff && !used_ff[pidx_ff] && (cand_size >= req_ff);
   assign take      = fits && (!found_ff || (cand_left > bleft_ff));

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      limit_in     = limit_ff;
      addr_in      = addr_ff;
      pend_in      = issue;
      pidx_in      = addr_ff[IDX_W-1:0];
      found_in     = found_ff;
      best_in      = best_ff;
      bleft_in     = bleft_ff;
      used_in      = used_ff;
      loaded_in    = loaded_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      if (take) begin
         found_in = 1'b1;
         best_in  = pidx_ff;
         bleft_in = cand_left;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_operation == OP_LOAD) begin
                  if (mem_we) begin
                     loaded_in[mem_waddr] = 1'b1;
                     used_in[mem_waddr]   = 1'b0;
                  end
               end else begin
                  req_in   = SIZE_BITS'(req_request_size);
                  limit_in = limit;
                  addr_in  = '0;
                  found_in = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               addr_in = addr_ff + LIM_W'(1);
            end else if (!pend_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in.granted      = found_ff;
               rsp_in.chosen_block = found_ff ? IDX_BITS'(best_ff) : '0;
               rsp_in.leftover     = found_ff ? OUT_BITS'(bleft_ff) : '0;
               if (found_ff) begin
                  used_in[best_ff] = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         used_ff      <= '0;
         loaded_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         used_ff      <= used_in;
         loaded_ff    <= loaded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      limit_ff <= limit_in;
      addr_ff  <= addr_in;
      pidx_ff  <= pidx_in;
      best_ff  <= best_in;
      bleft_ff <= bleft_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

@@ rtl/wfpa_checker.sv @@
// Port-level checks for the worst-fit partition allocator, bound to the top.
// Depends on wfpa_pkg and worst_fit_partition_allocator_core.
module wfpa_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          req_operation,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_granted,
   input logic [wfpa_pkg::IDX_BITS-1:0] rsp_chosen_block,
   input logic [wfpa_pkg::OUT_BITS-1:0] rsp_leftover
);
   import wfpa_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_granted) && $stable(rsp_chosen_block) &&
      $stable(rsp_leftover))
      else $error("stalled response changed");

   a_deny_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_granted |-> (rsp_chosen_block == '0) && (rsp_leftover == '0))
      else $error("denied response carries nonzero fields");

   a_alloc_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_operation == OP_ALLOC) |=> req_stall)
      else $error("allocate request did not hold off the next request");

   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_operation == OP_LOAD) && !rsp_valid |=> !rsp_valid)
      else $error("load request produced a response");

endmodule

bind worst_fit_partition_allocator_core wfpa_checker u_wfpa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_operation    (req_operation),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_granted      (rsp_granted),
   .rsp_chosen_block (rsp_chosen_block),
   .rsp_leftover     (rsp_leftover)
);

@@ verif/tb_worst_fit_partition_allocator_core.sv @@
// Self-checking testbench for worst_fit_partition_allocator_core: directed and random
// load/allocate traffic against a worst-fit predictor, with random request gaps and response stalls.
// Depends on rtl/wfpa_pkg.sv and rtl/worst_fit_partition_allocator_core.sv.
module tb_worst_fit_partition_allocator_core;
   timeunit 1ns;
   timeprecision 1ps;

   import wfpa_pkg::*;

   localparam int PARTS       = 16;
   localparam int SETTLE      = 30;
   localparam int IDLE_LIMIT  = 2000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_operation;
   logic [IDX_BITS-1:0]   req_block_index;
   logic [IN_BITS-1:0]    req_block_size;
   logic [IN_BITS-1:0]    req_request_size;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_granted;
   logic [IDX_BITS-1:0]   rsp_chosen_block;
   logic [OUT_BITS-1:0]   rsp_leftover;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CFG_BITS-1:0]   csr_num_blocks;

   logic [IN_BITS-1:0]    part_size [PARTS];
   logic                  part_used [PARTS];
   logic [CFG_BITS-1:0]   search_count;
   rsp_type               grant_q[$];

   bit                    idle_on;
   int unsigned           n_errors;
   int unsigned           n_loads;
   int unsigned           n_allocs;
   int unsigned           n_granted;
   int unsigned           n_refused;
   int unsigned           n_cfg;
   int unsigned           quiet_cycles;

   worst_fit_partition_allocator_core #(
      .NUM_PARTITIONS(PARTS),
      .SIZE_BITS(16)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_block_index(req_block_index),
      .req_block_size(req_block_size),
      .req_request_size(req_request_size),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_granted(rsp_granted),
      .rsp_chosen_block(rsp_chosen_block),
      .rsp_leftover(rsp_leftover),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_num_blocks(csr_num_blocks)
   );

   always #5 clock = ~clock;

   function automatic rsp_type predict_grant(logic [IN_BITS-1:0] need);
      rsp_type             r;
      int                  lim;
      logic [IN_BITS-1:0]  left;
      r = '0;
      lim = (search_count > PARTS) ? PARTS : int'(search_count);
      for (int j = 0; j < lim; j++) begin
         if (!part_used[j] && part_size[j] >= need) begin
            left = part_size[j] - need;
            if (!r.granted || left > r.leftover) begin
               r.granted      = 1'b1;
               r.chosen_block = IDX_BITS'(j);
               r.leftover     = left;
            end
         end
      end
      if (r.granted)
         part_used[r.chosen_block] = 1'b1;
      return r;
   endfunction

   function automatic logic [IN_BITS-1:0] pick_size();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2, 3: return IN_BITS'($urandom_range(0, 31));
         default: return IN_BITS'($urandom);
      endcase
   endfunction

   task automatic send_request(logic op, logic [IDX_BITS-1:0] idx,
                               logic [IN_BITS-1:0] bsize, logic [IN_BITS-1:0] rsize);
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_block_index  <= idx;
      req_block_size   <= bsize;
      req_request_size <= rsize;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == OP_LOAD) begin
         part_size[idx] = bsize;
         part_used[idx] = 1'b0;
         n_loads++;
      end else begin
         grant_q.push_back(predict_grant(rsize));
         n_allocs++;
      end
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   task automatic drain_grants();
      req_valid <= 1'b0;
      while (grant_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_search_count(logic [CFG_BITS-1:0] value);
      drain_grants();
      csr_valid      <= 1'b1;
      csr_num_blocks <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid    <= 1'b0;
      search_count = value;
      n_cfg++;
   endtask

   task automatic report(string what, logic [31:0] want, logic [31:0] got);
      n_errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
   endtask

   task automatic test_reset_state();
      send_request(OP_ALLOC, 4'd0, 16'd0, 16'd0);
      send_request(OP_ALLOC, 4'd0, 16'd0, 16'd1);
   endtask

   task automatic test_extremes();
      send_request(OP_LOAD, 4'd0, 16'hFFFF, 16'd0);
      send_request(OP_LOAD, 4'd15, 16'd0, 16'hFFFF);
      send_request(OP_LOAD, 4'd7, 16'h8000, 16'd0);
      send_request(OP_ALLOC, 4'd15, 16'hFFFF, 16'd0);
      send_request(OP_ALLOC, 4'd0, 16'd0, 16'hFFFF);
      send_request(OP_ALLOC, 4'd0, 16'd0, 16'h8000);
      send_request(OP_ALLOC, 4'd0, 16'd0, 16'd0);
   endtask

   task automatic test_ties();
      send_request(OP_LOAD, 4'd3, 16'd100, 16'd0);
      send_request(OP_LOAD, 4'd5, 16'd100, 16'd0);
      send_request(OP_LOAD, 4'd9, 16'd100, 16'd0);
      send_request(OP_ALLOC, 4'd0, 16'd0, 16'd40);
      send_request(OP_ALLOC, 4'd0, 16'd0, 16'd40);
      send_request(OP_LOAD, 4'd3, 16'd100, 16'd0);
      send_request(OP_ALLOC, 4'd0, 16'd0, 16'd40);
   endtask

   task automatic test_search_count();
      set_search_count(5'd0);
      send_request(OP_ALLOC, 4'd0, 16'd0, 16'd0);
      set_search_count(5'd1);
      send_request(OP_LOAD, 4'd0, 16'd5, 16'd0);
      send_request(OP_ALLOC, 4'd0, 16'd0, 16'd0);
      set_search_count(5'd31);
      send_request(OP_LOAD, 4'd15, 16'hFFFF, 16'd0);
      send_request(OP_ALLOC, 4'd0, 16'd0, 16'd1);
      set_search_count(5'd17);
      send_request(OP_ALLOC, 4'd0, 16'd0, 16'd0);
      set_search_count(5'd16);
   endtask

   task automatic test_random_traffic();
      logic [CFG_BITS-1:0] nb;
      int                  lim;
      for (int phase = 0; phase < 8; phase++) begin
         case ($urandom_range(0, 5))
            0: nb = CFG_BITS'($urandom_range(17, 31));
            1: nb = 5'd16;
            default: nb = CFG_BITS'($urandom_range(1, 16));
         endcase
         set_search_count(nb);
         lim = (nb > PARTS) ? PARTS : int'(nb);
         idle_on = (phase != 3) && (phase != 7);
         for (int k = 0; k < 128; k++) begin
            if ($urandom_range(0, 9) < 6)
               send_request(OP_LOAD,
                            ($urandom_range(0, 4) == 0) ? IDX_BITS'($urandom_range(0, 15))
                                                         : IDX_BITS'($urandom_range(0, lim - 1)),
                            pick_size(), IN_BITS'($urandom));
            else
               send_request(OP_ALLOC, IDX_BITS'($urandom_range(0, 15)), IN_BITS'($urandom),
                            pick_size());
            if ($urandom_range(0, 63) == 0)
               drain_grants();
         end
      end
   endtask

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (grant_q.size() == 0) begin
            n_errors++;
            $display("%0t: unexpected response, expected none actual granted=%0d block=%0d left=%0d",
                     $time, rsp_granted, rsp_chosen_block, rsp_leftover);
         end else begin
            want = grant_q.pop_front();
            if (want.granted) n_granted++;
            else n_refused++;
            if (rsp_granted !== want.granted)
               report("granted", 32'(want.granted), 32'(rsp_granted));
            if (rsp_chosen_block !== want.chosen_block)
               report("chosen_block", 32'(want.chosen_block), 32'(rsp_chosen_block));
            if (rsp_leftover !== want.leftover)
               report("leftover", 32'(want.leftover), 32'(rsp_leftover));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("%0t: timeout, no handshake for %0d cycles", $time, quiet_cycles);
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_operation    <= OP_LOAD;
      req_block_index  <= '0;
      req_block_size   <= '0;
      req_request_size <= '0;
      csr_valid        <= 1'b0;
      csr_num_blocks   <= CFG_RESET;
      quiet_cycles     <= 0;
      idle_on          = 1'b1;
      search_count     = CFG_RESET;
      for (int j = 0; j < PARTS; j++) begin
         part_size[j] = '0;
         part_used[j] = 1'b0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_extremes();
      test_ties();
      test_search_count();
      test_random_traffic();

      drain_grants();
      $display("Sent %0d loads and %0d allocates: %0d granted, %0d refused.",
               n_loads, n_allocs, n_granted, n_refused);
      $display("Used %0d search-count settings, from zero through saturating values.", n_cfg);
      if (n_errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

@@ worst_fit_partition_allocator_core.f @@
rtl/wfpa_pkg.sv
rtl/wfpa_size_mem.sv
rtl/wfpa_scan.sv
rtl/worst_fit_partition_allocator_core.sv
rtl/wfpa_checker.sv
verif/tb_worst_fit_partition_allocator_core.sv
